FILE: hw/rtl/dsp_pkg.sv
// Shared types and constants of the decimal string parser.
`default_nettype none

package dsp_pkg;

    localparam int unsigned DSP_MAX_SCALE = 38;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned MAG_HI_W  = 63;
    localparam int unsigned MAG_LO_W  = 64;
    localparam int unsigned MAG_W     = MAG_HI_W + MAG_LO_W;
    localparam int unsigned FRAC_W    = 6;
    localparam int unsigned EXP_W     = 32;

    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CH_W-1:0] CH_EXP_L = 8'h65;
    localparam logic [CH_W-1:0] CH_EXP_U = 8'h45;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXP_SIGN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXP_CHAR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRAILING  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EXP_RANGE = 3'd6;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } dsp_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsp_if.sv
// Character and result channel interfaces.
`default_nettype none

interface dsp_char_if
    import dsp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface dsp_res_if
    import dsp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic                       negative;
    logic [MAG_HI_W-1:0]        magnitude_high;
    logic [MAG_LO_W-1:0]        magnitude_low;
    logic [FRAC_W-1:0]          fraction_count;
    logic signed [EXP_W-1:0]    exponent_value;

    modport source (output valid, output status, output negative, output magnitude_high,
                    output magnitude_low, output fraction_count, output exponent_value,
                    input ready);
    modport sink   (input valid, input status, input negative, input magnitude_high,
                    input magnitude_low, input fraction_count, input exponent_value,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dsp_in_reg.sv
// Input register for the character channel.
`default_nettype none

module dsp_in_reg
    import dsp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dsp_char_if.sink    chars,
    output logic        item_valid,
    output dsp_item_t   item,
    input  wire logic   item_take
);

    logic      valid_reg;
    logic      valid_next;
    dsp_item_t item_reg;
    logic      load;

    assign chars.ready = !valid_reg || item_take;
    assign load        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.ch   <= chars.ch;
            item_reg.last <= chars.last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dsp_parse.sv
// Parser state, per-character update and result register.
`default_nettype none

module dsp_parse
    import dsp_pkg::*;
#(
    parameter int unsigned MAX_SCALE = DSP_MAX_SCALE
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire dsp_item_t  item,
    output logic            item_take,
    dsp_res_if.source       results
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_WHOLE = 3'd1;
    localparam logic [2:0] PH_FRAC  = 3'd2;
    localparam logic [2:0] PH_EXPS  = 3'd3;
    localparam logic [2:0] PH_EXPD  = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;

    localparam int unsigned XACC_W = 33;
    localparam logic [XACC_W-1:0] EXP_SAT     = 33'h1_0000_0000;
    localparam logic [XACC_W-1:0] EXP_NEG_MAX = 33'h0_8000_0000;
    localparam logic [XACC_W-1:0] EXP_POS_MAX = 33'h0_7fff_ffff;
    localparam logic [FRAC_W-1:0] SCALE_MAX   = FRAC_W'(MAX_SCALE);

    // Parser state
    logic [2:0]          phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                ovf_reg, ovf_next;
    logic                whole_reg, whole_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [XACC_W-1:0]   xacc_reg, xacc_next;
    logic                xsign_reg, xsign_next;
    logic                xneg_reg, xneg_next;
    logic                xdig_reg, xdig_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    // Result register
    logic                    rvalid_reg, rvalid_next;
    logic [STATUS_W-1:0]     rstatus_reg, rstatus_next;
    logic                    rneg_reg, rneg_next;
    logic [MAG_W-1:0]        rmag_reg, rmag_next;
    logic [FRAC_W-1:0]       rfrac_reg, rfrac_next;
    logic signed [EXP_W-1:0] rexp_reg, rexp_next;

    logic             advance;
    logic             is_digit;
    logic [3:0]       digit;
    logic [MAG_W+3:0] mag_x10;
    logic             mag_ovf;
    logic [XACC_W+3:0] xacc_x10;
    logic [XACC_W-1:0] xacc_dig;

    assign item_take = item_valid && (!item.last || !rvalid_reg || results.ready);
    assign advance   = item_take;

    assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign digit    = 4'(item.ch - CH_ZERO);

    // Times ten plus digit, with overflow past 2^127-1
    assign mag_x10 = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                   + {(MAG_W)'(0), digit};
    assign mag_ovf = (mag_x10[MAG_W+3:MAG_W] != 4'd0);

    assign xacc_x10 = {1'b0, xacc_reg, 3'b000} + {3'b000, xacc_reg, 1'b0}
                    + {(XACC_W)'(0), digit};
    assign xacc_dig = (xacc_x10 > {4'd0, EXP_SAT}) ? EXP_SAT : xacc_x10[XACC_W-1:0];

    always_comb
    begin
        logic                    skip;
        logic [2:0]              ph;
        logic [STATUS_W-1:0]     st;
        logic signed [EXP_W-1:0] expo;

        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        xacc_next  = xacc_reg;
        xsign_next = xsign_reg;
        xneg_next  = xneg_reg;
        xdig_next  = xdig_reg;
        err_next   = err_reg;
        skip       = 1'b0;
        ph         = phase_reg;
        st         = ST_OK;
        expo       = '0;

        if (ph == PH_START)
        begin
            ph = PH_WHOLE;
            if (item.ch == CH_MINUS)
            begin
                neg_next = 1'b1;
                skip     = 1'b1;
            end
            else if (item.ch == CH_PLUS)
            begin
                skip = 1'b1;
            end
        end
        phase_next = ph;

        if (!skip)
        begin
            case (ph)
                PH_WHOLE, PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (!ovf_reg)
                        begin
                            if (mag_ovf)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = mag_x10[MAG_W-1:0];
                            end
                        end
                        if (ph == PH_WHOLE)
                        begin
                            whole_next = 1'b1;
                        end
                        else
                        begin
                            if (frac_reg <= SCALE_MAX)
                            begin
                                frac_next = frac_reg + FRAC_W'(1);
                            end
                            if (frac_next > SCALE_MAX)
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    else if (ph == PH_WHOLE && item.ch == CH_DOT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else if (!whole_reg && frac_reg == '0)
                    begin
                        err_next   = ST_NO_DIGITS;
                        phase_next = PH_ERR;
                    end
                    else if (item.ch == CH_EXP_L || item.ch == CH_EXP_U)
                    begin
                        phase_next = PH_EXPS;
                    end
                    else
                    begin
                        err_next   = ST_TRAILING;
                        phase_next = PH_ERR;
                    end
                end
                PH_EXPS:
                begin
                    phase_next = PH_EXPD;
                    if (item.ch == CH_PLUS)
                    begin
                        xsign_next = 1'b1;
                    end
                    else if (item.ch == CH_MINUS)
                    begin
                        xsign_next = 1'b1;
                        xneg_next  = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        xacc_next = xacc_dig;
                        xdig_next = 1'b1;
                    end
                    else
                    begin
                        err_next   = ST_EXP_CHAR;
                        phase_next = PH_ERR;
                    end
                end
                PH_EXPD:
                begin
                    if (is_digit)
                    begin
                        xacc_next = xacc_dig;
                        xdig_next = 1'b1;
                    end
                    else
                    begin
                        err_next   = ST_EXP_CHAR;
                        phase_next = PH_ERR;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Final status from the updated state
        case (phase_next)
            PH_ERR:
            begin
                st = err_next;
            end
            PH_WHOLE, PH_FRAC:
            begin
                if (!whole_next && frac_next == '0)
                begin
                    st = ST_NO_DIGITS;
                end
            end
            PH_EXPS:
            begin
                st = ST_EXP_RANGE;
            end
            PH_EXPD:
            begin
                if (!xdig_next)
                begin
                    st = ST_EXP_SIGN;
                end
                else if (xneg_next)
                begin
                    if (xacc_next > EXP_NEG_MAX)
                    begin
                        st = ST_EXP_RANGE;
                    end
                    else
                    begin
                        expo = EXP_W'(~xacc_next + XACC_W'(1));
                    end
                end
                else
                begin
                    if (xacc_next > EXP_POS_MAX)
                    begin
                        st = ST_EXP_RANGE;
                    end
                    else
                    begin
                        expo = xacc_next[EXP_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (st == ST_OK && ovf_next)
        begin
            st = ST_TOO_LARGE;
        end

        rstatus_next = st;
        rneg_next    = neg_next;
        rmag_next    = (st == ST_OK) ? mag_next : '0;
        rfrac_next   = (st == ST_OK) ? frac_next : '0;
        rexp_next    = (st == ST_OK) ? expo : '0;

        // Drop all state after the last character of a text
        if (item.last)
        begin
            phase_next = PH_START;
            neg_next   = 1'b0;
            mag_next   = '0;
            ovf_next   = 1'b0;
            whole_next = 1'b0;
            frac_next  = '0;
            xacc_next  = '0;
            xsign_next = 1'b0;
            xneg_next  = 1'b0;
            xdig_next  = 1'b0;
            err_next   = ST_OK;
        end
    end

    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (advance && item.last)
        begin
            rvalid_next = 1'b1;
        end
        else if (results.ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            ovf_reg    <= 1'b0;
            whole_reg  <= 1'b0;
            frac_reg   <= '0;
            xacc_reg   <= '0;
            xsign_reg  <= 1'b0;
            xneg_reg   <= 1'b0;
            xdig_reg   <= 1'b0;
            err_reg    <= ST_OK;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
                whole_reg <= whole_next;
                frac_reg  <= frac_next;
                xacc_reg  <= xacc_next;
                xsign_reg <= xsign_next;
                xneg_reg  <= xneg_next;
                xdig_reg  <= xdig_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.last)
        begin
            rstatus_reg <= rstatus_next;
            rneg_reg    <= rneg_next;
            rmag_reg    <= rmag_next;
            rfrac_reg   <= rfrac_next;
            rexp_reg    <= rexp_next;
        end
    end

    assign results.valid          = rvalid_reg;
    assign results.status         = rstatus_reg;
    assign results.negative       = rneg_reg;
    assign results.magnitude_high = rmag_reg[MAG_W-1:MAG_LO_W];
    assign results.magnitude_low  = rmag_reg[MAG_LO_W-1:0];
    assign results.fraction_count = rfrac_reg;
    assign results.exponent_value = rexp_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && rstatus_reg != ST_OK) |->
            (rmag_reg == '0 && rfrac_reg == '0 && rexp_reg == '0))
        else $error("error result carries nonzero fields");

    a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && rstatus_reg == ST_OK) |-> (rfrac_reg <= SCALE_MAX))
        else $error("ok result exceeds scale limit");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.last) |=> (phase_reg == PH_START && !ovf_reg && err_reg == ST_OK))
        else $error("state not cleared after last character");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR) |-> (err_reg == ST_NO_DIGITS || err_reg == ST_EXP_CHAR ||
                                   err_reg == ST_TRAILING))
        else $error("error phase without a text error code");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rvalid_reg && !results.ready) |=> (rvalid_reg && $stable(rstatus_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/decimal_string_parser_top.sv
// Top level of the decimal string parser.
`default_nettype none

// Parses a decimal text (optional sign, whole digits, optional dot and
// fraction digits, optional exponent) arriving one ASCII character per item
// on chars, with last set on the final character. One result item per text
// comes out on results: status, sign, a 127-bit magnitude holding all digits
// including the fraction, the fraction digit count and a signed 32-bit
// exponent. The block takes one character every cycle; each character passes
// an input register and then one times-ten update of the 127-bit magnitude,
// and the result is registered when the parser takes its last character. A
// result that is not taken holds the next last character in the parser,
// while characters with last clear keep flowing.
module decimal_string_parser_top
    import dsp_pkg::*;
#(
    parameter int unsigned MAX_SCALE = DSP_MAX_SCALE
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dsp_char_if.sink    chars,
    dsp_res_if.source   results
);

    logic      item_valid;
    dsp_item_t item;
    logic      item_take;

    dsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    dsp_parse #(
        .MAX_SCALE (MAX_SCALE)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .results    (results)
    );

endmodule

`default_nettype wire
